// ===== sv/bmp_to_rgba_stream_decoder_assert.svh =====
// Assertion macros for the BMP decoder.
`ifndef BMP_TO_RGBA_STREAM_DECODER_ASSERT_SVH
`define BMP_TO_RGBA_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BRSD_ASSERT_NOW(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define BRSD_ASSERT_NEXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

// ===== sv/brsd_pkg.sv =====
package brsd_pkg;

  localparam int unsigned MAX_DIM = 4096;

  localparam logic [15:0] BMP_MAGIC    = 16'h4D42;
  localparam logic [31:0] INFO_HDR_LEN = 32'd40;
  localparam logic [5:0]  HDR_LEN      = 6'd54;
  localparam logic [9:0]  PAL_LAST     = 10'd1023;

  // header byte offsets where a field is complete
  localparam logic [5:0] OFF_MAGIC  = 6'd1;
  localparam logic [5:0] OFF_FSIZE  = 6'd5;
  localparam logic [5:0] OFF_INFO   = 6'd17;
  localparam logic [5:0] OFF_WIDTH  = 6'd21;
  localparam logic [5:0] OFF_HEIGHT = 6'd25;
  localparam logic [5:0] OFF_BPP    = 6'd29;
  localparam logic [5:0] OFF_COMPR  = 6'd33;

  localparam logic [15:0] BPP_8  = 16'd8;
  localparam logic [15:0] BPP_24 = 16'd24;
  localparam logic [15:0] BPP_32 = 16'd32;

  localparam logic [5:0] MUL_STEPS = 6'd32;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_MAGIC     = 3'd2,
    ST_UNSUPP    = 3'd3,
    ST_SIZE      = 3'd4,
    ST_TRUNC     = 3'd5,
    ST_TOO_LARGE = 3'd6
  } status_t;

  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_CHECK   = 5'b00010,
    PH_PALETTE = 5'b00100,
    PH_PIXELS  = 5'b01000,
    PH_DRAIN   = 5'b10000
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] word;
    logic [11:0] col;
    logic [11:0] row;
    logic [12:0] width;
    logic [12:0] height;
    status_t     status;
    logic        last;
  } result_t;

  typedef struct packed {
    logic               full;
    logic               empty;
    logic [FIFO_CW-1:0] count;
  } fifo_stat_t;

  typedef struct packed {
    logic checking;
    logic in_pixels;
  } front_stat_t;

endpackage

// ===== sv/bmp_to_rgba_stream_decoder.sv =====
// Channel | Handshake           | Beat
// --------+---------------------+-------------------------------------------
// in      | push / full         | data_byte, end_of_file (one file byte)
// out     | pop / empty         | kind, pixel word, column, row, width,
//         |                     | height, status, last_pixel
//
// One file byte per cycle in header, palette and pixel phases while the
// result queue is not full. After the 54th header byte the size check
// runs a shift-add multiply of row stride by height, full held high meanwhile.
// A 4-entry result queue decouples the parser from the consumer; full also
// rises when that queue is full. rst_n is synchronous, active low.
`include "bmp_to_rgba_stream_decoder_assert.svh"

module bmp_to_rgba_stream_decoder import brsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_file,
  output logic        in_full,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [1:0]  out_result_kind,
  output logic [31:0] out_pixel_word,
  output logic [11:0] out_pixel_column,
  output logic [11:0] out_pixel_row,
  output logic [12:0] out_image_width,
  output logic [12:0] out_image_height,
  output logic [2:0]  out_status_code,
  output logic        out_last_pixel
);

  logic        byte_ready;
  logic        res_valid;
  result_t     res, head;
  front_stat_t fstat;
  fifo_stat_t  qstat;

  // parser: header, check, palette skip, pixel formatting
  brsd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_valid  (in_push),
    .data_byte   (in_data_byte),
    .end_of_file (in_end_of_file),
    .q_full      (qstat.full),
    .byte_ready  (byte_ready),
    .res_valid   (res_valid),
    .res         (res),
    .stat        (fstat)
  );

  // result queue
  brsd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_valid),
    .wdata (res),
    .pop   (out_pop),
    .rdata (head),
    .stat  (qstat)
  );

  assign in_full          = !byte_ready;
  assign out_empty        = qstat.empty;
  assign out_result_kind  = head.kind;
  assign out_pixel_word   = head.word;
  assign out_pixel_column = head.col;
  assign out_pixel_row    = head.row;
  assign out_image_width  = head.width;
  assign out_image_height = head.height;
  assign out_status_code  = head.status;
  assign out_last_pixel   = head.last;

  // no byte taken while the size check is running
  `BRSD_ASSERT_NOW(a_no_take_in_check, fstat.checking, in_full, "byte taken during check")
  // the parser never offers a result into a full queue
  `BRSD_ASSERT_NOW(a_no_overflow, res_valid, !qstat.full, "result pushed into full queue")
  // pixel phase yields only pixels or a truncation error
  `BRSD_ASSERT_NOW(a_pix_kind, fstat.in_pixels && res_valid, res.kind != KIND_HEADER, "header in pixels")
  // a pop with no push shrinks the queue by one
  `BRSD_ASSERT_NEXT(a_pop_count, out_pop && !out_empty && !res_valid,
                    qstat.count == $past(qstat.count) - FIFO_CW'(1), "queue count off")

endmodule

// ===== sv/brsd_front.sv =====
module brsd_front import brsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_valid,
  input  logic [7:0]  data_byte,
  input  logic        end_of_file,
  input  logic        q_full,
  output logic        byte_ready,
  output logic        res_valid,
  output result_t     res,
  output front_stat_t stat
);

  phase_t      phase_r, phase_nxt;
  logic [5:0]  hcnt_r, hcnt_nxt;
  logic [31:0] hshift_r, hshift_nxt;
  logic [31:0] fsize_r, fsize_nxt;
  logic [31:0] width_r, width_nxt;
  logic [31:0] height_r, height_nxt;
  logic [15:0] bpp_r, bpp_nxt;
  logic [2:0]  fok_r, fok_nxt;
  logic [9:0]  pal_r, pal_nxt;
  logic [11:0] col_r, col_nxt;
  logic [11:0] row_r, row_nxt;
  logic [1:0]  bip_r, bip_nxt;
  logic [23:0] asm_r, asm_nxt;
  logic [1:0]  pad_r, pad_nxt;
  logic        eof_r, eof_nxt;
  logic [5:0]  mcnt_r, mcnt_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic        ovf_r, ovf_nxt;
  logic [34:0] rb_r, rb_nxt;

  logic        take;
  logic [31:0] sh;
  logic [35:0] mul_t;
  logic [33:0] diff;
  logic        fmt_ok, size_bad, too_large, owed;
  status_t     st;
  logic [11:0] w1, h1;
  logic [1:0]  w3, need;
  logic        last;
  logic [31:0] word;

  assign byte_ready = (phase_r != PH_CHECK) && !q_full;
  assign take       = byte_valid && byte_ready;
  assign stat.checking  = (phase_r == PH_CHECK);
  assign stat.in_pixels = (phase_r == PH_PIXELS);

  assign sh    = {data_byte, hshift_r[31:8]};
  assign mul_t = {2'b0, acc_r, 1'b0} + ((height_r[5'(31 - mcnt_r[4:0])]) ?
                 {1'b0, rb_r} : 36'd0);
  assign diff  = {2'b0, fsize_r} - {2'b0, acc_r} - 34'd54;

  assign fmt_ok    = (bpp_r == BPP_8 || bpp_r == BPP_24 || bpp_r == BPP_32) &&
                     (fok_r[2:1] == 2'b11);
  assign size_bad  = (bpp_r == BPP_24) && (ovf_r || diff[33] || (diff[32:0] > 33'd4));
  assign too_large = (width_r > 32'(MAX_DIM)) || (height_r > 32'(MAX_DIM));
  assign owed      = (width_r != 32'd0) && (height_r != 32'd0);

  always_comb begin
    if (!fok_r[0]) st = ST_MAGIC;
    else if (!fmt_ok) st = ST_UNSUPP;
    else if (size_bad) st = ST_SIZE;
    else if (too_large) st = ST_TOO_LARGE;
    else st = ST_OK;
  end

  assign w1   = width_r[11:0] - 12'd1;
  assign h1   = height_r[11:0] - 12'd1;
  assign w3   = width_r[1:0] + {width_r[0], 1'b0};
  assign need = (bpp_r == BPP_32) ? 2'd3 : 2'd2;
  assign last = (col_r == w1) && (row_r == h1);

  always_comb begin
    if (bpp_r == BPP_8) word = {8'hFF, data_byte, data_byte, data_byte};
    else if (bpp_r == BPP_32) word = {data_byte, asm_r};
    else word = {8'hFF, asm_r[7:0], asm_r[15:8], data_byte};
  end

  always_comb begin
    phase_nxt  = phase_r;
    hcnt_nxt   = hcnt_r;
    hshift_nxt = hshift_r;
    fsize_nxt  = fsize_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    bpp_nxt    = bpp_r;
    fok_nxt    = fok_r;
    pal_nxt    = pal_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    bip_nxt    = bip_r;
    asm_nxt    = asm_r;
    pad_nxt    = pad_r;
    eof_nxt    = eof_r;
    mcnt_nxt   = mcnt_r;
    acc_nxt    = acc_r;
    ovf_nxt    = ovf_r;
    rb_nxt     = rb_r;
    res_valid  = 1'b0;
    res        = '0;

    case (phase_r)
      PH_HEADER: begin
        if (take) begin
          hshift_nxt = sh;
          hcnt_nxt   = hcnt_r + 6'd1;
          if (hcnt_r == OFF_MAGIC && sh[31:16] == BMP_MAGIC) fok_nxt[0] = 1'b1;
          if (hcnt_r == OFF_FSIZE) fsize_nxt = sh;
          if (hcnt_r == OFF_INFO && sh == INFO_HDR_LEN) fok_nxt[1] = 1'b1;
          if (hcnt_r == OFF_WIDTH) width_nxt = sh;
          if (hcnt_r == OFF_HEIGHT) height_nxt = sh;
          if (hcnt_r == OFF_BPP) bpp_nxt = sh[31:16];
          if (hcnt_r == OFF_COMPR && sh == 32'd0) fok_nxt[2] = 1'b1;
          if (hcnt_nxt == HDR_LEN) begin
            // 24-bpp row stride, rounded up to 4 bytes
            rb_nxt    = ({1'b0, width_r, 2'b0} - {3'b0, width_r} + 35'd3) & ~35'd3;
            phase_nxt = PH_CHECK;
            eof_nxt   = end_of_file;
            mcnt_nxt  = '0;
            acc_nxt   = '0;
            ovf_nxt   = 1'b0;
          end else if (end_of_file) begin
            res_valid  = 1'b1;
            res.kind   = KIND_ERROR;
            res.status = ST_SHORT;
          end
        end
      end
      PH_CHECK: begin
        if (mcnt_r != MUL_STEPS) begin
          mcnt_nxt = mcnt_r + 6'd1;
          acc_nxt  = mul_t[31:0];
          if (mul_t[35:32] != 4'd0) ovf_nxt = 1'b1;
        end else if (!q_full) begin
          res_valid = 1'b1;
          if (st != ST_OK) begin
            res.kind   = KIND_ERROR;
            res.status = st;
            phase_nxt  = PH_DRAIN;
          end else begin
            res.kind   = KIND_HEADER;
            res.width  = width_r[12:0];
            res.height = height_r[12:0];
            if (bpp_r == BPP_8) phase_nxt = PH_PALETTE;
            else phase_nxt = owed ? PH_PIXELS : PH_DRAIN;
            if (eof_r && phase_nxt != PH_DRAIN) begin
              res.kind   = KIND_ERROR;
              res.width  = '0;
              res.height = '0;
              res.status = ST_TRUNC;
            end
          end
        end
      end
      PH_PALETTE: begin
        if (take) begin
          pal_nxt = pal_r + 10'd1;
          if (pal_r == PAL_LAST) phase_nxt = owed ? PH_PIXELS : PH_DRAIN;
          if (end_of_file && phase_nxt != PH_DRAIN) begin
            res_valid  = 1'b1;
            res.kind   = KIND_ERROR;
            res.status = ST_TRUNC;
          end
        end
      end
      PH_PIXELS: begin
        if (take) begin
          if (pad_r != 2'd0) begin
            pad_nxt = pad_r - 2'd1;
          end else if (bpp_r != BPP_8 && bip_r < need) begin
            asm_nxt = asm_r | (24'(data_byte) << {bip_r, 3'b0});
            bip_nxt = bip_r + 2'd1;
          end else begin
            bip_nxt    = '0;
            asm_nxt    = '0;
            res_valid  = 1'b1;
            res.kind   = KIND_PIXEL;
            res.word   = word;
            res.col    = col_r;
            res.row    = (bpp_r == BPP_24) ? (h1 - row_r) : row_r;
            res.last   = last;
            if (last) begin
              phase_nxt = PH_DRAIN;
            end else if (col_r == w1) begin
              col_nxt = '0;
              row_nxt = row_r + 12'd1;
              if (bpp_r == BPP_24) pad_nxt = 2'(2'd0 - w3);
            end else begin
              col_nxt = col_r + 12'd1;
            end
          end
          if (end_of_file && phase_nxt == PH_PIXELS) begin
            res_valid = 1'b1;
            res       = '0;
            res.kind   = KIND_ERROR;
            res.status = ST_TRUNC;
          end
        end
      end
      PH_DRAIN: ;
      default: phase_nxt = PH_HEADER;
    endcase

    // end of file puts the parser back to its reset state
    if ((take && end_of_file && phase_nxt != PH_CHECK) ||
        (phase_r == PH_CHECK && res_valid && eof_r)) begin
      phase_nxt  = PH_HEADER;
      hcnt_nxt   = '0;
      hshift_nxt = '0;
      fsize_nxt  = '0;
      width_nxt  = '0;
      height_nxt = '0;
      bpp_nxt    = '0;
      fok_nxt    = '0;
      pal_nxt    = '0;
      col_nxt    = '0;
      row_nxt    = '0;
      bip_nxt    = '0;
      asm_nxt    = '0;
      pad_nxt    = '0;
      eof_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      hcnt_r   <= '0;
      hshift_r <= '0;
      fsize_r  <= '0;
      width_r  <= '0;
      height_r <= '0;
      bpp_r    <= '0;
      fok_r    <= '0;
      pal_r    <= '0;
      col_r    <= '0;
      row_r    <= '0;
      bip_r    <= '0;
      asm_r    <= '0;
      pad_r    <= '0;
      eof_r    <= 1'b0;
      mcnt_r   <= '0;
      acc_r    <= '0;
      ovf_r    <= 1'b0;
      rb_r     <= '0;
    end else begin
      phase_r  <= phase_nxt;
      hcnt_r   <= hcnt_nxt;
      hshift_r <= hshift_nxt;
      fsize_r  <= fsize_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      bpp_r    <= bpp_nxt;
      fok_r    <= fok_nxt;
      pal_r    <= pal_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      bip_r    <= bip_nxt;
      asm_r    <= asm_nxt;
      pad_r    <= pad_nxt;
      eof_r    <= eof_nxt;
      mcnt_r   <= mcnt_nxt;
      acc_r    <= acc_nxt;
      ovf_r    <= ovf_nxt;
      rb_r     <= rb_nxt;
    end
  end

endmodule

// ===== sv/brsd_fifo.sv =====
module brsd_fifo import brsd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  result_t    wdata,
  input  logic       pop,
  output result_t    rdata,
  output fifo_stat_t stat
);

  result_t             mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wp_r, rp_r;
  logic [FIFO_CW-1:0]  cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign stat.full  = (cnt_r == FIFO_CW'(FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign stat.count = cnt_r;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + FIFO_CW'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - FIFO_CW'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + FIFO_AW'(1);
      if (do_pop) rp_r <= rp_r + FIFO_AW'(1);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import brsd_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic [7:0]  in_data_byte;
  logic        in_end_of_file;
  logic        in_full;
  logic        out_pop;
  logic        out_empty;
  logic [1:0]  out_result_kind;
  logic [31:0] out_pixel_word;
  logic [11:0] out_pixel_column;
  logic [11:0] out_pixel_row;
  logic [12:0] out_image_width;
  logic [12:0] out_image_height;
  logic [2:0]  out_status_code;
  logic        out_last_pixel;

  bmp_to_rgba_stream_decoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_data_byte     (in_data_byte),
    .in_end_of_file   (in_end_of_file),
    .in_full          (in_full),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_result_kind  (out_result_kind),
    .out_pixel_word   (out_pixel_word),
    .out_pixel_column (out_pixel_column),
    .out_pixel_row    (out_pixel_row),
    .out_image_width  (out_image_width),
    .out_image_height (out_image_height),
    .out_status_code  (out_status_code),
    .out_last_pixel   (out_last_pixel)
  );

  // Watchdog: cycles with no beat on either side. Covers the size check
  // plus the long receiver hold-off with wide margin.
  localparam int STALL_LIMIT = 5000;

  int          errors = 0;
  int          stall_cycles = 0;
  int          hold_cycles = 0;  // one-shot long receiver hold-off
  bit          no_idle = 0;      // stretch with no gaps on either side
  result_t     expected_results[$];
  logic [7:0]  bmp_bytes[$];     // file under construction

  // Decoder state mirror
  phase_t      dec_phase;
  int          dec_hdr_count;
  logic [31:0] dec_shift;
  logic [31:0] dec_fsize;
  logic [31:0] dec_width;
  logic [31:0] dec_height;
  logic [15:0] dec_bpp;
  logic [2:0]  dec_flags;        // magic, info header 40, no compression
  int          dec_pal_count;
  logic [31:0] dec_col;
  logic [31:0] dec_row;
  int          dec_byte_in_pix;
  logic [23:0] dec_assembly;
  logic [31:0] dec_pad;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Decoder prediction
  // ---------------------------------------------------------------------
  function automatic void clear_decoder();
    dec_phase       = PH_HEADER;
    dec_hdr_count   = 0;
    dec_shift       = '0;
    dec_fsize       = '0;
    dec_width       = '0;
    dec_height      = '0;
    dec_bpp         = '0;
    dec_flags       = '0;
    dec_pal_count   = 0;
    dec_col         = '0;
    dec_row         = '0;
    dec_byte_in_pix = 0;
    dec_assembly    = '0;
    dec_pad         = '0;
  endfunction

  function automatic status_t header_status();
    longint unsigned stride;
    longint unsigned hh;
    longint          slack;
    if (!dec_flags[0]) return ST_MAGIC;
    if ((dec_bpp != BPP_8 && dec_bpp != BPP_24 && dec_bpp != BPP_32) ||
        dec_flags[2:1] != 2'b11) return ST_UNSUPP;
    if (dec_bpp == BPP_24) begin
      // 24 bpp: file size must match padded rows plus 0..4 bytes slack
      stride = (64'(dec_width) * 3 + 3) & ~64'd3;
      hh = 64'(dec_height);
      if (hh != 0 && stride > 64'hFFFF_FFFF / hh) return ST_SIZE;
      slack = longint'(64'(dec_fsize)) - longint'(stride * hh) - 54;
      if (slack < 0 || slack > 4) return ST_SIZE;
    end
    if (dec_width > MAX_DIM || dec_height > MAX_DIM) return ST_TOO_LARGE;
    return ST_OK;
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic eof);
    result_t     r;
    bit          have;
    int          off;
    status_t     st;
    logic [31:0] word;
    bit          last;
    r = '0;
    have = 0;
    case (dec_phase)
      PH_HEADER: begin
        off = dec_hdr_count;
        dec_shift = {b, dec_shift[31:8]};
        dec_hdr_count++;
        if (off == OFF_MAGIC && dec_shift[31:16] == BMP_MAGIC) dec_flags[0] = 1'b1;
        if (off == OFF_FSIZE) dec_fsize = dec_shift;
        if (off == OFF_INFO && dec_shift == INFO_HDR_LEN) dec_flags[1] = 1'b1;
        if (off == OFF_WIDTH) dec_width = dec_shift;
        if (off == OFF_HEIGHT) dec_height = dec_shift;
        if (off == OFF_BPP) dec_bpp = dec_shift[31:16];
        if (off == OFF_COMPR && dec_shift == 0) dec_flags[2] = 1'b1;
        if (dec_hdr_count >= HDR_LEN) begin
          st = header_status();
          have = 1;
          if (st != ST_OK) begin
            r.kind = KIND_ERROR;
            r.status = st;
            dec_phase = PH_DRAIN;
          end else begin
            r.kind = KIND_HEADER;
            r.width = dec_width[12:0];
            r.height = dec_height[12:0];
            if (dec_bpp == BPP_8) dec_phase = PH_PALETTE;
            else if (dec_width != 0 && dec_height != 0) dec_phase = PH_PIXELS;
            else dec_phase = PH_DRAIN;
          end
        end else if (eof) begin
          r.kind = KIND_ERROR;
          r.status = ST_SHORT;
          have = 1;
        end
      end
      PH_PALETTE: begin
        dec_pal_count++;
        if (dec_pal_count >= 1024)
          dec_phase = (dec_width != 0 && dec_height != 0) ? PH_PIXELS : PH_DRAIN;
      end
      PH_PIXELS: begin
        if (dec_pad != 0) begin
          dec_pad--;
        end else if (dec_bpp != BPP_8 &&
                     dec_byte_in_pix < ((dec_bpp == BPP_32) ? 3 : 2)) begin
          dec_assembly[8*dec_byte_in_pix +: 8] = b;
          dec_byte_in_pix++;
        end else begin
          if (dec_bpp == BPP_8) word = {8'hFF, b, b, b};
          else if (dec_bpp == BPP_32) word = {b, dec_assembly};
          else word = {8'hFF, dec_assembly[7:0], dec_assembly[15:8], b};
          dec_byte_in_pix = 0;
          dec_assembly = '0;
          last = (dec_col == dec_width - 1) && (dec_row == dec_height - 1);
          have = 1;
          r.kind = KIND_PIXEL;
          r.word = word;
          r.col = dec_col[11:0];
          r.row = (dec_bpp == BPP_24) ? 12'(dec_height - 1 - dec_row) : dec_row[11:0];
          r.last = last;
          if (last) begin
            dec_phase = PH_DRAIN;
          end else if (dec_col == dec_width - 1) begin
            dec_col = '0;
            dec_row++;
            if (dec_bpp == BPP_24) dec_pad = (32'd0 - 3 * dec_width) & 32'd3;
          end else begin
            dec_col++;
          end
        end
      end
      default: ;
    endcase
    if (eof) begin
      // an end of file while palette or pixels are still owed overrides whatever this byte produced
      if (dec_phase == PH_PALETTE || dec_phase == PH_PIXELS) begin
        r = '0;
        r.kind = KIND_ERROR;
        r.status = ST_TRUNC;
        have = 1;
      end
      clear_decoder();
    end
    if (have) expected_results.push_back(r);
  endfunction

  // ---------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------
  function automatic int gap_len();
    int p;
    if (no_idle) return 0;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // One file byte beat; prediction runs at the accepting edge.
  task automatic send_byte(input logic [7:0] b, input logic eof);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push        <= 1'b1;
    in_data_byte   <= b;
    in_end_of_file <= eof;
    do @(posedge clk); while (in_full);
    predict_byte(b, eof);
  endtask

  // Receiver: random pop gaps, plus a one-shot long hold-off on request.
  initial begin
    int g;
    out_pop <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_pop <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else begin
        g = gap_len();
        if (g == 0) begin
          out_pop <= 1'b1;
        end else begin
          out_pop <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
    end
  end

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Result checker: every popped beat against the oldest expectation.
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result beat: kind %0d status %0d", out_result_kind,
               out_status_code);
        errors++;
      end else begin
        e = expected_results.pop_front();
        check_field("result_kind", 32'(e.kind), 32'(out_result_kind));
        check_field("pixel_word", e.word, out_pixel_word);
        check_field("pixel_column", 32'(e.col), 32'(out_pixel_column));
        check_field("pixel_row", 32'(e.row), 32'(out_pixel_row));
        check_field("image_width", 32'(e.width), 32'(out_image_width));
        check_field("image_height", 32'(e.height), 32'(out_image_height));
        check_field("status_code", 32'(e.status), 32'(out_status_code));
        check_field("last_pixel", 32'(e.last), 32'(out_last_pixel));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // File construction
  // ---------------------------------------------------------------------
  function automatic void put_le(logic [31:0] v, int n);
    for (int i = 0; i < n; i++) bmp_bytes.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_random(int n);
    for (int i = 0; i < n; i++) bmp_bytes.push_back(8'($urandom));
  endfunction

  function automatic void put_header(logic [31:0] fsize, logic [31:0] w, logic [31:0] h,
                                     logic [15:0] bpp, logic [15:0] magic = BMP_MAGIC,
                                     logic [31:0] info = INFO_HDR_LEN,
                                     logic [31:0] compr = 0);
    put_le(32'(magic), 2);
    put_le(fsize, 4);
    put_le($urandom, 4);  // reserved
    put_le($urandom, 4);  // data offset, ignored by the block
    put_le(info, 4);
    put_le(w, 4);
    put_le(h, 4);
    put_le(1, 2);
    put_le(32'(bpp), 2);
    put_le(compr, 4);
    put_random(20);
  endfunction

  function automatic logic [31:0] size_24(int w, int h, int slack);
    return 32'(54 + ((w * 3 + 3) & ~3) * h + slack);
  endfunction

  // Well-formed header, palette and pixel payload for a w x h image.
  function automatic void put_image(int w, int h, logic [15:0] bpp, int slack = 0);
    logic [31:0] fsize;
    fsize = (bpp == BPP_24) ? size_24(w, h, slack) : 32'($urandom);
    put_header(fsize, w, h, bpp);
    if (bpp == BPP_8) put_random(1024);
    if (bpp == BPP_24) put_random(((w * 3 + 3) & ~3) * h);
    else put_random(w * h * (bpp / 8));
  endfunction

  // Sends the first n bytes (all if n < 0) with end of file on the last.
  task automatic send_file(input int n = -1);
    int cnt;
    cnt = (n < 0 || n > bmp_bytes.size()) ? bmp_bytes.size() : n;
    for (int i = 0; i < cnt; i++) send_byte(bmp_bytes[i], i == cnt - 1);
    bmp_bytes.delete();
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  task automatic test_short_header();
    put_header(0, 1, 1, BPP_32);
    send_file(1);                 // lone byte
    put_header(0, 1, 1, BPP_32);
    send_file(53);                // one byte short
  endtask

  task automatic test_bad_magic();
    put_header(0, 1, 1, BPP_32, 16'h4D43);
    put_random(2);
    send_file();
  endtask

  task automatic test_unsupported();
    put_header(0, 1, 1, 16'd16);
    send_file();
    put_header(0, 1, 1, BPP_8, BMP_MAGIC, INFO_HDR_LEN, 32'd1);
    send_file();
  endtask

  task automatic test_size_slack();
    put_header(size_24(3, 2, 5), 3, 2, BPP_24);   // one byte too many
    send_file();
    put_header(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, BPP_24);  // overflow
    send_file();
    put_image(3, 1, BPP_24, 4);                     // largest slack allowed
    send_file();
  endtask

  task automatic test_too_large();
    put_header(0, 4097, 1, BPP_32);
    send_file();
  endtask

  task automatic test_empty_image();
    put_header(0, 0, 5, BPP_32);
    put_random(2);
    send_file();
  endtask

  task automatic test_each_depth();
    put_image(2, 1, BPP_32);
    send_file();
    put_image(3, 2, BPP_24);      // three padding bytes per row
    send_file();
  endtask

  // Width at the size limit is accepted; the file ends after two pixels.
  task automatic test_extreme_width();
    put_header(0, MAX_DIM, 1, BPP_32);
    put_random(8);
    send_file();
  endtask

  task automatic test_truncated();
    put_image(2, 2, BPP_8);
    send_file(54);                // end on header byte
    put_image(2, 2, BPP_8);
    send_file(60);                // end inside palette
    put_image(2, 2, BPP_24);
    send_file(54 + 7);            // end inside padding
  endtask

  // One padding byte per row, then bytes past the last pixel.
  task automatic test_trailing_bytes();
    put_image(1, 2, BPP_24);
    put_random(3);
    send_file();
  endtask

  // Receiver stalls while the sender keeps offering bytes; the result
  // queue fills and the block must push back on its input.
  task automatic test_backpressure();
    no_idle = 1;
    hold_cycles = 300;
    put_image(3, 2, BPP_32);
    send_file();
    no_idle = 0;
  endtask

  initial begin
    clear_decoder();
    rst_n          <= 1'b0;
    in_push        <= 1'b0;
    in_data_byte   <= '0;
    in_end_of_file <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_short_header();
    test_bad_magic();
    test_unsupported();
    test_size_slack();
    test_too_large();
    test_empty_image();
    test_each_depth();
    test_truncated();
    test_trailing_bytes();
    test_backpressure();
    test_extreme_width();

    in_push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
